/* rtl/pss_pkg.sv */
`default_nettype none

package pss_pkg;

	// input word operations
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_TICKS_PER_STEP = 2'd0;
	localparam logic [1:0] REG_OUTPUT_CHANNEL = 2'd1;
	localparam logic [1:0] REG_PATTERN_SELECT = 2'd2;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd3;

	// event kinds
	localparam logic KIND_PLAY = 1'b0;
	localparam logic KIND_STOP = 1'b1;

	localparam int NUM_PATTERNS_DEF = 16;
	localparam int MAX_STEPS_DEF    = 64;

	localparam logic [6:0] PATTERN_LENGTH_RST = 7'd64;

	// one stored pattern slot, 27 bits
	typedef struct packed {
		logic [5:0]  duration;
		logic [15:0] frequency;
		logic [3:0]  instrument;
		logic        present;
	} slot_t;

	// one result word
	typedef struct packed {
		logic        kind;
		logic [3:0]  channel;
		logic [3:0]  instrument;
		logic [15:0] frequency;
	} event_t;

endpackage

`default_nettype wire

/* rtl/pattern_step_sequencer_unit.sv */
`default_nettype none

// Pattern step sequencer. Slots live in one synchronous memory of
// NUM_PATTERNS * MAX_STEPS entries; a write word loads a slot, a start word
// arms playback at step 0 with one leading step of wait, each tick word
// spends the tick count (reloaded from ticks_per_step) and then the remaining
// duration, and when both are spent the slot at the current step of the
// selected pattern is read: a present note emits a play event and advances
// by its duration (0 counts as 1), a rest emits a stop event and advances by
// one. A stop word emits a stop event and halts. Rate: one input word per
// clock while the output queue has room, except that a tick which reads a
// slot holds in_ready low until the new step and duration, which the next
// tick needs, come back from the slot memory's registered read; that
// read-modify-write loop sets the limit. Results pass through a two-word
// output queue, so input keeps flowing while a result waits for out_ready.
// After reset the block clears all NUM_PATTERNS * MAX_STEPS slot memory
// entries (1024 by default), one entry per clock, and holds in_ready low
// until then; configuration writes are taken throughout. Configuration
// registers are live and should be written only while the block is idle.
module pattern_step_sequencer_unit #(
	parameter int NUM_PATTERNS = pss_pkg::NUM_PATTERNS_DEF,
	parameter int MAX_STEPS    = pss_pkg::MAX_STEPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [9:0]  slot_address,
	input  wire logic        slot_present,
	input  wire logic [3:0]  slot_instrument,
	input  wire logic [15:0] slot_frequency,
	input  wire logic [5:0]  slot_duration,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             event_kind,
	output logic [3:0]       event_channel,
	output logic [3:0]       event_instrument,
	output logic [15:0]      event_frequency
);

	localparam int DEPTH = NUM_PATTERNS * MAX_STEPS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(MAX_STEPS);
	localparam int LW    = $clog2(MAX_STEPS + 1);
	localparam int NW    = $clog2(MAX_STEPS + 64);

	// configuration
	logic [15:0] ticks_per_step_q;
	logic [3:0]  output_channel_q;
	logic [3:0]  pattern_select_q;
	logic [6:0]  pattern_length_q;

	// playback state
	logic        running_q;
	logic [15:0] tick_cd_q;
	logic [5:0]  dur_cd_q;
	logic [SW-1:0] step_q;

	// clearing pass
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// slot memory
	pss_pkg::slot_t slot_mem [DEPTH];
	pss_pkg::slot_t slot_rd_s1;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	pss_pkg::slot_t mem_wdata;
	logic           mem_re;
	logic [AW-1:0]  mem_raddr;

	// stage 1: result pending, and whether it comes from a slot read
	logic          res_s1;
	logic          fire_s1;
	logic          sel_ok_s1;
	logic [SW-1:0] rstep_s1;

	// output queue
	pss_pkg::event_t out_fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	logic            accept;
	logic            pop;
	logic            fire;
	logic [LW-1:0]   eff_len;
	logic [SW-1:0]   rstep;
	logic [31:0]     raddr_full;
	logic [31:0]     waddr_full;
	logic            sel_ok;
	logic [2:0]      room_need;
	logic [2:0]      room_have;

	pss_pkg::event_t res_event;
	logic            play;
	logic [5:0]      dur_eff;
	logic [NW-1:0]   nstep;
	logic [SW-1:0]   step_next;

	// effective pattern length: zero counts as one, clamp to MAX_STEPS
	always_comb begin
		if (pattern_length_q == 7'd0) begin
			eff_len = LW'(1);
		end else if (32'(pattern_length_q) > MAX_STEPS) begin
			eff_len = LW'(MAX_STEPS);
		end else begin
			eff_len = LW'(pattern_length_q);
		end
	end

	// input flow control: no word while clearing or while a slot read is in
	// flight, and keep room in the queue for the pending result and the next
	assign pop       = out_valid && out_ready;
	assign room_need = {1'b0, cnt_q} + {2'b0, res_s1};
	assign room_have = 3'd1 + {2'b0, pop};
	assign in_ready  = !clr_q && !fire_s1 && (room_need <= room_have);
	assign accept    = in_valid && in_ready;

	// a tick fires when running and both counts are spent
	assign fire = accept && (op == pss_pkg::OP_TICK) && running_q &&
		(tick_cd_q == 16'd0) && (dur_cd_q == 6'd0);

	// wrap the step when the length has shrunk under it
	assign rstep      = (32'(step_q) >= 32'(eff_len)) ? '0 : step_q;
	assign sel_ok     = 32'(pattern_select_q) < NUM_PATTERNS;
	assign raddr_full = 32'(pattern_select_q) * 32'(MAX_STEPS) + 32'(rstep);
	assign waddr_full = 32'(slot_address);

	assign mem_re    = fire;
	assign mem_raddr = raddr_full[AW-1:0];

	always_comb begin
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = accept && (op == pss_pkg::OP_WRITE) && (waddr_full < 32'(DEPTH));
			mem_waddr = waddr_full[AW-1:0];
			mem_wdata = '{duration: slot_duration, frequency: slot_frequency,
				instrument: slot_instrument, present: slot_present};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			slot_rd_s1 <= slot_mem[mem_raddr];
		end
	end

	// stage 1: form the event and the next step from the slot read
	always_comb begin
		play      = fire_s1 && sel_ok_s1 && slot_rd_s1.present;
		dur_eff   = (slot_rd_s1.duration == 6'd0) ? 6'd1 : slot_rd_s1.duration;
		nstep     = play ? (NW'(rstep_s1) + NW'(dur_eff)) : (NW'(rstep_s1) + NW'(1));
		step_next = (32'(nstep) >= 32'(eff_len)) ? '0 : nstep[SW-1:0];
		res_event.channel = output_channel_q;
		if (play) begin
			res_event.kind       = pss_pkg::KIND_PLAY;
			res_event.instrument = slot_rd_s1.instrument;
			res_event.frequency  = slot_rd_s1.frequency;
		end else begin
			res_event.kind       = pss_pkg::KIND_STOP;
			res_event.instrument = 4'd0;
			res_event.frequency  = 16'd0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_step_q <= 16'd0;
			output_channel_q <= 4'd0;
			pattern_select_q <= 4'd0;
			pattern_length_q <= pss_pkg::PATTERN_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pss_pkg::REG_TICKS_PER_STEP: ticks_per_step_q <= cfg_data;
				pss_pkg::REG_OUTPUT_CHANNEL: output_channel_q <= cfg_data[3:0];
				pss_pkg::REG_PATTERN_SELECT: pattern_select_q <= cfg_data[3:0];
				pss_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[6:0];
			endcase
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// playback control and stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			tick_cd_q <= 16'd0;
			dur_cd_q  <= 6'd0;
			step_q    <= '0;
			res_s1    <= 1'b0;
			fire_s1   <= 1'b0;
			sel_ok_s1 <= 1'b0;
			rstep_s1  <= '0;
		end else begin
			res_s1  <= 1'b0;
			fire_s1 <= 1'b0;
			if (fire_s1) begin
				// write back what the slot read decided
				dur_cd_q <= play ? (dur_eff - 6'd1) : 6'd0;
				step_q   <= step_next;
			end
			if (accept) begin
				unique case (op)
					pss_pkg::OP_START: begin
						running_q <= 1'b1;
						tick_cd_q <= 16'd0;
						dur_cd_q  <= 6'd1;
						step_q    <= '0;
					end
					pss_pkg::OP_STOP: begin
						running_q <= 1'b0;
						res_s1    <= 1'b1;
					end
					pss_pkg::OP_TICK: begin
						if (running_q) begin
							if (tick_cd_q != 16'd0) begin
								tick_cd_q <= tick_cd_q - 16'd1;
							end else begin
								tick_cd_q <= ticks_per_step_q;
								if (dur_cd_q != 6'd0) begin
									dur_cd_q <= dur_cd_q - 6'd1;
								end else begin
									res_s1    <= 1'b1;
									fire_s1   <= 1'b1;
									sel_ok_s1 <= sel_ok;
									rstep_s1  <= rstep;
								end
							end
						end
					end
					pss_pkg::OP_WRITE: begin
						// slot memory write handled on the memory port
					end
				endcase
			end
		end
	end

	// two-word output queue
	always_ff @(posedge clk) begin
		if (res_s1) begin
			out_fifo_q[wr_ptr_q] <= res_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (res_s1) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, res_s1} - {1'b0, pop};
		end
	end

	assign out_valid        = cnt_q != 2'd0;
	assign event_kind       = out_fifo_q[rd_ptr_q].kind;
	assign event_channel    = out_fifo_q[rd_ptr_q].channel;
	assign event_instrument = out_fifo_q[rd_ptr_q].instrument;
	assign event_frequency  = out_fifo_q[rd_ptr_q].frequency;

`ifndef SYNTH
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !accept)
		else $error("word accepted during clearing pass");

	a_fire_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |-> res_s1)
		else $error("slot read without a pending result");

	a_no_back_to_back_fire: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> !fire_s1)
		else $error("slot read issued while previous one in flight");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_s1 && cnt_q == 2'd2) |-> pop)
		else $error("output queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");
`endif

endmodule

`default_nettype wire
